FILE: hdl/pmts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic message scheduler package
// Shared types, message codes, register indexes and per-message constants.
// ----------------------------------------------------------------------------
package pmts_pkg;

  localparam int BUDGET_MAX_DEF   = 64;
  localparam int SEQ_ID_LIMIT_DEF = 253;
  localparam int QUEUE_DEPTH      = 2;
  localparam int SEQ_SLOTS        = 6;
  localparam int MSG_COUNT        = 9;

  localparam logic [3:0] MSG_RAPID      = 4'd0;
  localparam logic [3:0] MSG_ALERT      = 4'd1;
  localparam logic [3:0] MSG_ALERT_TEXT = 4'd2;
  localparam logic [3:0] MSG_STATUS_A   = 4'd3;
  localparam logic [3:0] MSG_STATUS_B   = 4'd4;
  localparam logic [3:0] MSG_STATUS_C   = 4'd5;
  localparam logic [3:0] MSG_TELEMETRY  = 4'd6;
  localparam logic [3:0] MSG_PRODUCT    = 4'd7;
  localparam logic [3:0] MSG_CONFIG     = 4'd8;

  localparam logic [2:0] REG_PRODUCT_PRESENT = 3'd0;
  localparam logic [2:0] REG_ALERT_FRAMES    = 3'd1;
  localparam logic [2:0] REG_STATUS_FRAMES   = 3'd2;
  localparam logic [2:0] REG_TELEMETRY_FRAMES = 3'd3;
  localparam logic [2:0] REG_PRODUCT_FRAMES  = 3'd4;
  localparam logic [2:0] REG_INSTALL_FRAMES  = 3'd5;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        addr_settled;
    logic        alert_active;
    logic [6:0]  frame_budget;
    logic [5:0]  alert_text_frames;
  } in_t;

  typedef struct packed {
    logic [3:0] message;
    logic [2:0] seq_num;
    logic [7:0] seq_id;
    logic [5:0] first_frame;
    logic [5:0] frame_count;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        alert_active;
    logic [6:0]  budget;
    logic [5:0]  text_frames;
  } tick_t;

  typedef struct packed {
    logic       product_present;
    logic [5:0] alert_frames;
    logic [5:0] status_frames;
    logic [5:0] telemetry_frames;
    logic [5:0] product_frames;
    logic [5:0] install_frames;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_FLUSH
  } back_state_t;

  function automatic logic [31:0] period_ms(input logic [3:0] msg);
    logic [31:0] p;
    unique case (msg)
      MSG_RAPID:                   p = 32'd100;
      MSG_ALERT:                   p = 32'd1000;
      MSG_ALERT_TEXT:              p = 32'd2500;
      MSG_PRODUCT, MSG_CONFIG:     p = 32'd5000;
      default:                     p = 32'd1500;
    endcase
    return p;
  endfunction

  function automatic logic has_seq(input logic [3:0] msg);
    return !(msg == MSG_RAPID || msg == MSG_STATUS_A || msg == MSG_STATUS_C);
  endfunction

  function automatic logic [2:0] seq_slot(input logic [3:0] msg);
    logic [2:0] s;
    unique case (msg)
      MSG_ALERT:      s = 3'd0;
      MSG_ALERT_TEXT: s = 3'd1;
      MSG_STATUS_B:   s = 3'd2;
      MSG_TELEMETRY:  s = 3'd3;
      MSG_PRODUCT:    s = 3'd4;
      MSG_CONFIG:     s = 3'd5;
      default:        s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: hdl/periodic_message_tx_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic message transmit scheduler
// Picks which periodic messages go out on each millisecond tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one transaction per tick (time, address flag, alert flag, frame
//            budget, alert text frame need). Ticks without a settled address
//            are taken and dropped with no effect.
//   out_*  : one transaction per message sent, in priority order; last marks
//            the final one of a tick. A tick that sends nothing gives none.
//   cfg_*  : register writes, always ready; write only while the block idles.
// Timing:
//   A tick leaves the two-entry queue once the back end is idle, then passes
//   through a start step, the message walk (one message per cycle through
//   the shared deadline compare, while the receiver keeps up) and a flush
//   step. A stalled receiver holds the result register and the walk waits
//   on the next send; the queue keeps accepting until it fills.
// Reset:
//   Clears deadlines, sequence counters, sequence id, queue and result valid;
//   registers return to their defaults.
// ----------------------------------------------------------------------------
module periodic_message_tx_scheduler_core
  import pmts_pkg::*;
#(
  parameter int BUDGET_MAX   = BUDGET_MAX_DEF,
  parameter int SEQ_ID_LIMIT = SEQ_ID_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [5:0] cfg_data
);

  cfg_t  cfg;
  logic  q_valid;
  logic  q_pop;
  tick_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.product_present  <= 1'b0;
      cfg.alert_frames     <= 6'd3;
      cfg.status_frames    <= 6'd1;
      cfg.telemetry_frames <= 6'd4;
      cfg.product_frames   <= 6'd20;
      cfg.install_frames   <= 6'd6;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PRODUCT_PRESENT:  cfg.product_present  <= cfg_data[0];
        REG_ALERT_FRAMES:     cfg.alert_frames     <= cfg_data;
        REG_STATUS_FRAMES:    cfg.status_frames    <= cfg_data;
        REG_TELEMETRY_FRAMES: cfg.telemetry_frames <= cfg_data;
        REG_PRODUCT_FRAMES:   cfg.product_frames   <= cfg_data;
        REG_INSTALL_FRAMES:   cfg.install_frames   <= cfg_data;
        default: ;
      endcase
    end
  end

  pmts_front #(
    .BUDGET_MAX(BUDGET_MAX)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_data  (q_data)
  );

  pmts_back #(
    .SEQ_ID_LIMIT(SEQ_ID_LIMIT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

`ifndef ASSERT_OFF
  a_msg_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.message <= MSG_CONFIG)
    else $error("message code out of range");

  a_single_frame : assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.message == MSG_RAPID || out_data.message == MSG_STATUS_A ||
                  out_data.message == MSG_STATUS_C)
    |-> out_data.seq_num == 3'd0 && out_data.frame_count == 6'd1)
    else $error("single-frame message with sequence or frame count");

  a_nonzero_need : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.frame_count != 6'd0)
    else $error("message sent with zero frames");
`endif

endmodule

FILE: hdl/pmts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts ticks, drops those without a settled address, clamps the frame
// budget and queues the rest for the back end.
// ----------------------------------------------------------------------------
module pmts_front
  import pmts_pkg::*;
#(
  parameter int BUDGET_MAX = BUDGET_MAX_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  output logic  q_valid,
  input  logic  q_pop,
  output tick_t q_data
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  tick_t              slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;
  logic [6:0]         budget_sat;
  tick_t              entry;

  assign in_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready && in_data.addr_settled;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != '0);
  assign q_data   = slot[rd_ptr];

  always_comb begin
    if ({2'b00, in_data.frame_budget} > 9'(BUDGET_MAX)) begin
      budget_sat = 7'(BUDGET_MAX);
    end else begin
      budget_sat = in_data.frame_budget;
    end
    entry.now_ms       = in_data.now_ms;
    entry.alert_active = in_data.alert_active;
    entry.budget       = budget_sat;
    entry.text_frames  = in_data.alert_text_frames;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/pmts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler back end
// Walks the nine messages of one tick in priority order, one per cycle while
// the receiver keeps up, keeps deadlines and sequence counters, and drives the result register.
// ----------------------------------------------------------------------------
module pmts_back
  import pmts_pkg::*;
#(
  parameter int SEQ_ID_LIMIT = SEQ_ID_LIMIT_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_valid,
  output logic  q_pop,
  input  tick_t q_data,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  back_state_t state;
  back_state_t state_next;

  logic [31:0] deadlines [MSG_COUNT];
  logic [2:0]  seq_counters [SEQ_SLOTS];
  logic [7:0]  tick_seq_id;

  tick_t       tick;
  logic [7:0]  sid;
  logic [3:0]  msg;
  logic [6:0]  used;
  logic        pend_valid;
  out_t        pend;

  logic [5:0]  need;
  logic        enabled;
  logic        due;
  logic        fits;
  logic        send;
  logic        out_free;
  logic        advance;
  logic        do_start;
  logic        do_step;
  logic        do_flush;
  logic        out_push;
  logic [31:0] diff;
  logic [6:0]  left;
  logic [2:0]  seq_cur;
  logic [8:0]  sid_inc;
  out_t        result;
  out_t        out_data_next;

  always_comb begin
    unique case (msg)
      MSG_ALERT:      need = cfg.alert_frames;
      MSG_ALERT_TEXT: need = tick.text_frames;
      MSG_STATUS_B:   need = cfg.status_frames;
      MSG_TELEMETRY:  need = cfg.telemetry_frames;
      MSG_PRODUCT:    need = cfg.product_frames;
      MSG_CONFIG:     need = cfg.install_frames;
      default:        need = 6'd1;
    endcase
    enabled = !((msg == MSG_ALERT || msg == MSG_ALERT_TEXT) && !tick.alert_active) &&
              !(msg == MSG_PRODUCT && !cfg.product_present);
    diff    = tick.now_ms - deadlines[msg];
    due     = !diff[31];
    left    = tick.budget - used;
    fits    = (need != 6'd0) && ({1'b0, need} <= left);
    send    = enabled && due && fits;
    seq_cur = has_seq(msg) ? seq_counters[seq_slot(msg)] : 3'd0;

    result.message     = msg;
    result.seq_num     = seq_cur;
    result.seq_id      = sid;
    result.first_frame = used[5:0];
    result.frame_count = need;
    result.last        = 1'b0;

    out_free = !out_valid || out_ready;
    advance  = !(send && pend_valid && !out_free);
    sid_inc  = {1'b0, tick_seq_id} + 9'd1;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    do_start   = 1'b0;
    do_step    = 1'b0;
    do_flush   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          do_start   = 1'b1;
          state_next = BK_WALK;
        end
      end
      BK_WALK: begin
        if (advance) begin
          do_step = 1'b1;
          if (msg == MSG_CONFIG) begin
            state_next = BK_FLUSH;
          end
        end
      end
      BK_FLUSH: begin
        if (!pend_valid) begin
          state_next = BK_IDLE;
        end else if (out_free) begin
          do_flush   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign out_push = (do_step && send && pend_valid) || do_flush;

  always_comb begin
    out_data_next      = pend;
    out_data_next.last = do_flush;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MSG_COUNT; i++) begin
        deadlines[i] <= '0;
      end
      for (int i = 0; i < SEQ_SLOTS; i++) begin
        seq_counters[i] <= '0;
      end
      tick_seq_id <= '0;
      msg         <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (do_start) begin
        tick_seq_id <= (sid_inc >= 9'(SEQ_ID_LIMIT)) ? 8'd0 : sid_inc[7:0];
        msg         <= '0;
        if (!q_data.alert_active) begin
          deadlines[MSG_ALERT]      <= q_data.now_ms;
          deadlines[MSG_ALERT_TEXT] <= q_data.now_ms;
        end
      end
      if (do_step) begin
        msg <= msg + 1'b1;
        if (send) begin
          deadlines[msg] <= tick.now_ms + period_ms(msg);
          if (has_seq(msg)) begin
            seq_counters[seq_slot(msg)] <= seq_cur + 1'b1;
          end
          pend_valid <= 1'b1;
        end
      end
      if (do_flush) begin
        pend_valid <= 1'b0;
      end
      if (out_push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      tick <= q_data;
      sid  <= tick_seq_id;
      used <= '0;
    end
    if (do_step && send) begin
      used <= used + 7'(need);
      pend <= result;
    end
    if (out_push) begin
      out_data <= out_data_next;
    end
  end

endmodule
